// File: rtl/wdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Watchdog package
// Command and status codes, option flags and the word types shared by the
// watchdog top level and its core.
// ----------------------------------------------------------------------------
package wdt_pkg;

    typedef enum logic [3:0] {
        CMD_TICK        = 4'd0,
        CMD_OPEN        = 4'd1,
        CMD_CLOSE       = 4'd2,
        CMD_WRITE_BYTE  = 4'd3,
        CMD_GET_SUPPORT = 4'd4,
        CMD_GET_STATUS  = 4'd5,
        CMD_GET_BOOT    = 4'd6,
        CMD_GET_TEMP    = 4'd7,
        CMD_SET_OPTIONS = 4'd8,
        CMD_KEEPALIVE   = 4'd9,
        CMD_SET_TIMEOUT = 4'd10,
        CMD_GET_TIMEOUT = 4'd11,
        CMD_SET_PRE     = 4'd12,
        CMD_GET_PRE     = 4'd13,
        CMD_GET_LEFT    = 4'd14,
        CMD_UNKNOWN     = 4'd15
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_ADDR = 3'd1,
        ST_INVALID  = 3'd2,
        ST_NOT_SUPP = 3'd3,
        ST_UNKNOWN  = 3'd4
    } status_t;

    localparam logic [15:0] OPT_SETTIMEOUT = 16'h0080;
    localparam logic [15:0] OPT_MAGICCLOSE = 16'h0100;
    localparam logic [15:0] OPT_KEEPALIVE  = 16'h8000;

    localparam logic [7:0]  MAGIC_BYTE     = 8'h56;   // 'V'
    localparam int          RESET_TIMEOUT  = 60;

    typedef struct packed {
        cmd_t               cmd;
        logic               arg_present;
        logic signed [31:0] value;
        logic [7:0]         data_byte;
    } wdt_req_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] read_value;
        logic        support_ack;
        logic        reset_request;
    } wdt_rsp_t;

endpackage

// File: rtl/wdt_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Watchdog command channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface wdt_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         cmd;
    logic               arg_present;
    logic signed [31:0] value;
    logic [7:0]         data_byte;

    modport source (output valid, cmd, arg_present, value, data_byte, input ready);
    modport sink   (input valid, cmd, arg_present, value, data_byte, output ready);
endinterface

// File: rtl/wdt_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Watchdog response channel
// Valid/ready channel carrying one response word.
// ----------------------------------------------------------------------------
interface wdt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] read_value;
    logic        support_ack;
    logic        reset_request;

    modport source (output valid, status, read_value, support_ack, reset_request,
                    input ready);
    modport sink   (input valid, status, read_value, support_ack, reset_request,
                    output ready);
endinterface

// File: rtl/wdt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Watchdog core
// Timer state and command decode. The response is combinational from the
// command word and the state; the state updates when fire is high.
// ----------------------------------------------------------------------------
module wdt_core #(
    parameter int MAX_TIMEOUT_SECONDS = 3600,
    parameter int TICKS_PER_SECOND    = 1000
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  wdt_pkg::wdt_req_t req,
    output wdt_pkg::wdt_rsp_t rsp
);
    import wdt_pkg::*;

    localparam int TW_RAW = $clog2(MAX_TIMEOUT_SECONDS + 1);
    localparam int TW     = (TW_RAW > 6) ? TW_RAW : 6;
    localparam int RW     = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [RW-1:0] MS_TOP = RW'(TICKS_PER_SECOND - 1);

    // countdown held as whole seconds plus ticks (milliseconds at the default rate) left in the current one
    logic          armed_reg,   armed_next;
    logic          magic_reg,   magic_next;
    logic [TW-1:0] timeout_reg, timeout_next;
    logic [TW-1:0] pre_reg,     pre_next;
    logic [TW-1:0] sec_reg,     sec_next;
    logic [RW-1:0] ms_reg,      ms_next;

    logic          needs_arg;
    logic          reload;
    logic          cnt_zero;
    logic [TW-1:0] sec_dec;
    logic [RW-1:0] ms_dec;
    logic          to_ok;
    logic          pre_ok;

    assign cnt_zero = (sec_reg == '0) && (ms_reg == '0);
    assign to_ok    = !req.value[31] && (req.value != 32'sd0)
                      && (req.value[30:0] <= 31'(MAX_TIMEOUT_SECONDS));
    assign pre_ok   = !req.value[31] && (req.value[30:0] < 31'(timeout_reg));

    always_comb
    begin
        unique case (req.cmd) inside
            CMD_GET_SUPPORT, CMD_GET_STATUS, CMD_GET_BOOT, CMD_SET_OPTIONS,
            CMD_SET_TIMEOUT, CMD_GET_TIMEOUT, CMD_SET_PRE, CMD_GET_PRE,
            CMD_GET_LEFT:
                needs_arg = 1'b1;
            default:
                needs_arg = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cnt_zero)
        begin
            sec_dec = sec_reg;
            ms_dec  = ms_reg;
        end
        else if (ms_reg == '0)
        begin
            sec_dec = sec_reg - 1'b1;
            ms_dec  = MS_TOP;
        end
        else
        begin
            sec_dec = sec_reg;
            ms_dec  = ms_reg - 1'b1;
        end
    end

    always_comb
    begin
        armed_next   = armed_reg;
        magic_next   = magic_reg;
        timeout_next = timeout_reg;
        pre_next     = pre_reg;
        sec_next     = sec_reg;
        ms_next      = ms_reg;
        reload       = 1'b0;
        rsp.status        = ST_OK;
        rsp.read_value    = '0;
        rsp.support_ack   = 1'b0;
        rsp.reset_request = 1'b0;

        if (needs_arg && !req.arg_present)
        begin
            rsp.status = ST_BAD_ADDR;
        end
        else
        begin
            unique case (req.cmd)
                CMD_TICK:
                begin
                    if (armed_reg)
                    begin
                        sec_next = sec_dec;
                        ms_next  = ms_dec;
                        if ((sec_dec == '0) && (ms_dec == '0))
                        begin
                            armed_next        = 1'b0;
                            rsp.reset_request = 1'b1;
                        end
                    end
                end
                CMD_OPEN:
                begin
                    armed_next = 1'b1;
                    magic_next = 1'b0;
                    reload     = 1'b1;
                end
                CMD_CLOSE:
                begin
                    if (magic_reg)
                        armed_next = 1'b0;
                    magic_next = 1'b0;
                end
                CMD_WRITE_BYTE:
                begin
                    if (req.data_byte == MAGIC_BYTE)
                        magic_next = 1'b1;
                    reload = 1'b1;
                end
                CMD_GET_SUPPORT:
                begin
                    rsp.read_value  = OPT_SETTIMEOUT | OPT_KEEPALIVE | OPT_MAGICCLOSE;
                    rsp.support_ack = 1'b1;
                end
                CMD_GET_STATUS:
                begin
                    if (armed_reg)
                        rsp.read_value = OPT_KEEPALIVE | OPT_SETTIMEOUT;
                end
                CMD_GET_BOOT:
                begin
                    rsp.read_value = '0;
                end
                CMD_GET_TEMP:
                begin
                    rsp.status = ST_NOT_SUPP;
                end
                CMD_SET_OPTIONS:
                begin
                    if (req.value[0])
                        armed_next = 1'b0;
                    if (req.value[1])
                    begin
                        armed_next = 1'b1;
                        reload     = 1'b1;
                    end
                end
                CMD_KEEPALIVE:
                begin
                    reload = 1'b1;
                end
                CMD_SET_TIMEOUT:
                begin
                    if (to_ok)
                    begin
                        timeout_next   = TW'(req.value[30:0]);
                        reload         = 1'b1;
                        rsp.read_value = 16'(req.value[30:0]);
                    end
                    else
                    begin
                        rsp.status = ST_INVALID;
                    end
                end
                CMD_GET_TIMEOUT:
                begin
                    rsp.read_value = 16'(timeout_reg);
                end
                CMD_SET_PRE:
                begin
                    if (pre_ok)
                    begin
                        pre_next       = TW'(req.value[30:0]);
                        rsp.read_value = 16'(req.value[30:0]);
                    end
                    else
                    begin
                        rsp.status = ST_INVALID;
                    end
                end
                CMD_GET_PRE:
                begin
                    rsp.read_value = 16'(pre_reg);
                end
                CMD_GET_LEFT:
                begin
                    // ceil to whole seconds: a part-used second counts as one
                    if (armed_reg && !cnt_zero)
                        rsp.read_value = 16'(sec_reg) + 16'(ms_reg != '0);
                end
                default:
                begin
                    rsp.status = ST_UNKNOWN;
                end
            endcase
        end

        if (reload)
        begin
            sec_next = timeout_next;
            ms_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            magic_reg   <= 1'b0;
            timeout_reg <= TW'(RESET_TIMEOUT);
            pre_reg     <= '0;
            sec_reg     <= '0;
            ms_reg      <= '0;
        end
        else if (fire)
        begin
            armed_reg   <= armed_next;
            magic_reg   <= magic_next;
            timeout_reg <= timeout_next;
            pre_reg     <= pre_next;
            sec_reg     <= sec_next;
            ms_reg      <= ms_next;
        end
    end

    a_ms_range: assert property (@(posedge clk) disable iff (!rst_n)
        ms_reg <= MS_TOP)
        else $error("millisecond count out of range");

    a_timeout_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        timeout_reg != '0)
        else $error("timeout register holds zero");

    a_expire_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        fire && rsp.reset_request |=> !armed_reg && (sec_reg == '0) && (ms_reg == '0))
        else $error("expiry left the timer armed or counting");

    a_open_arms: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req.cmd == CMD_OPEN) |=> armed_reg && !magic_reg
            && (sec_reg == timeout_reg) && (ms_reg == '0))
        else $error("open did not arm and reload");

endmodule

// File: rtl/watchdog_timer_with_magic_close_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Watchdog timer with magic close
// Command-driven watchdog: millisecond ticks, keepalive, magic-close disarm
// and timeout/pretimeout register access.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command word (cmd, arg_present, value, data_byte); rsp
//   returns exactly one response word (status, read_value, support_ack,
//   reset_request) per command, in order.
//   A command is registered on acceptance and decoded against the timer state
//   from the input register; the response is loaded into the output register
//   when that register is empty or its word is being taken. One command per
//   cycle is sustained while rsp is not stalled; the decode between the two
//   registers is combinational.
//   reset_request is high in the response to the tick on which the armed
//   countdown runs out; the timer is then disarmed.
//   Reset leaves the timer disarmed, magic close cleared, timeout 60 s,
//   pretimeout 0 and the countdown at zero.
//   While rsp is stalled the response word holds and one more command is
//   taken into the input register; req.ready then drops until rsp moves.
// ----------------------------------------------------------------------------
module watchdog_timer_with_magic_close_unit #(
    parameter int MAX_TIMEOUT_SECONDS = 3600,
    parameter int TICKS_PER_SECOND    = 1000
) (
    input  logic       clk,
    input  logic       rst_n,
    wdt_req_if.sink    req,
    wdt_rsp_if.source  rsp
);
    import wdt_pkg::*;

    logic     in_valid_reg;
    wdt_req_t in_word_reg;
    logic     out_valid_reg;
    wdt_rsp_t out_word_reg;
    wdt_rsp_t core_rsp;
    wdt_req_t in_word_next;
    logic     advance;
    logic     take;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign take      = req.valid && req.ready;

    assign in_word_next.cmd         = cmd_t'(req.cmd);
    assign in_word_next.arg_present = req.arg_present;
    assign in_word_next.value       = req.value;
    assign in_word_next.data_byte   = req.data_byte;

    wdt_core #(
        .MAX_TIMEOUT_SECONDS (MAX_TIMEOUT_SECONDS),
        .TICKS_PER_SECOND    (TICKS_PER_SECOND)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .req   (in_word_reg),
        .rsp   (core_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_word_reg <= in_word_next;
        if (advance)
            out_word_reg <= core_rsp;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_word_reg.status;
    assign rsp.read_value    = out_word_reg.read_value;
    assign rsp.support_ack   = out_word_reg.support_ack;
    assign rsp.reset_request = out_word_reg.reset_request;

endmodule
